@@ rtl/assert_macros.svh @@
// Assertion helpers for the region table block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define URRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("region table check failed");

// next-cycle implication
`define URRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("region table check failed");

`endif

@@ rtl/urrt_pkg.sv @@
package urrt_pkg;

  localparam int unsigned REGION_SLOTS = 16;
  localparam longint unsigned PAGE_BYTES = 64'd4096;

  localparam int unsigned SLOT_IW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam logic [SLOT_IW-1:0] SLOT_LAST = SLOT_IW'(REGION_SLOTS - 1);

  localparam logic [63:0] PAGE_ADD  = 64'(PAGE_BYTES - 64'd1);
  localparam logic [63:0] PAGE_MASK = ~PAGE_ADD;

  localparam int unsigned CFG_AW = 6;

  typedef enum logic [2:0] {
    REG_WIN_BASE  = 3'd0,
    REG_WIN_LIMIT = 3'd1,
    REG_USER_MASK = 3'd2,
    REG_GUARD_MASK = 3'd3,
    REG_SPACE_RDY = 3'd4,
    REG_PROC_OWN  = 3'd5
  } reg_idx_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ADD   = 7'b0000010,
    S_ROUND = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_FIND  = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_LOOK  = 7'b1000000
  } state_t;

  // slot number as reported: index mod 16
  function automatic logic [3:0] slot_out(input logic [SLOT_IW-1:0] idx);
    logic [SLOT_IW+3:0] w;
    w = (SLOT_IW + 4)'(idx);
    return w[3:0];
  endfunction

endpackage

@@ rtl/user_region_reserve_table_core.sv @@
// Channel   Handshake                       Payload
// input     start / busy                    in_kind, in_address, in_length, in_request_flags
// result    out_valid (one-cycle strobe)    out_ok, out_slot, out_region_*
// config    APB write/read, pready tied 1   paddr (8-byte regs), pwdata, prdata
//
// Reserve: address arithmetic (add, round, check) on the shared 64-bit adder, then a
// scan of one slot per cycle (up to 16), then a write. Failed checks or a full table refuse.
// Lookup: one slot per cycle through the same adder, up to the first hit or the last slot.
// The registered result strobe shows in the cycle after the last step; busy drops with it.
// Synchronous reset clears the used marks, count and config registers.
// The receiver cannot stall; a new beat may be started while a strobe shows.
`include "assert_macros.svh"

module user_region_reserve_table_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [63:0]                   in_address,
  input  logic [63:0]                   in_length,
  input  logic [63:0]                   in_request_flags,
  output logic                          out_valid,
  output logic                          out_ok,
  output logic [3:0]                    out_slot,
  output logic [63:0]                   out_region_base,
  output logic [63:0]                   out_region_bytes,
  output logic [63:0]                   out_region_flags,
  output logic [4:0]                    out_region_total,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [urrt_pkg::CFG_AW-1:0]   paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  import urrt_pkg::*;

  // configuration
  logic [63:0] win_base_r, win_limit_r, user_mask_r, guard_mask_r;
  logic        space_rdy_r, proc_own_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  // control
  state_t             state_r, state_nxt;
  logic [SLOT_IW-1:0] idx_r, idx_nxt;
  logic [REGION_SLOTS-1:0] used_r, used_nxt;
  logic [4:0]         total_r, total_nxt;

  // payload
  logic [63:0] addr_r, len_r, req_r;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] size_r, size_nxt;
  logic [63:0] slot_base_r  [REGION_SLOTS];
  logic [63:0] slot_size_r  [REGION_SLOTS];
  logic [63:0] slot_flags_r [REGION_SLOTS];
  logic        wr_en;

  // shared adder
  logic [63:0] add_a, add_b, sum;
  logic        add_cin;

  // result
  logic        emit, emit_ok;
  logic [63:0] emit_base, emit_bytes, emit_flags;
  logic        out_valid_r, out_ok_r;
  logic [3:0]  out_slot_r;
  logic [63:0] out_base_r, out_bytes_r, out_flags_r;
  logic [4:0]  out_total_r;

  logic [63:0] base_cur, flags_new;
  logic        good, hit, last;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:3]);

  always_comb begin
    unique case (cfg_idx)
      REG_WIN_BASE:   prdata = win_base_r;
      REG_WIN_LIMIT:  prdata = win_limit_r;
      REG_USER_MASK:  prdata = user_mask_r;
      REG_GUARD_MASK: prdata = guard_mask_r;
      REG_SPACE_RDY:  prdata = {63'd0, space_rdy_r};
      REG_PROC_OWN:   prdata = {63'd0, proc_own_r};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_base_r   <= '0;
      win_limit_r  <= '0;
      user_mask_r  <= '0;
      guard_mask_r <= '0;
      space_rdy_r  <= 1'b0;
      proc_own_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIN_BASE:   win_base_r   <= pwdata;
        REG_WIN_LIMIT:  win_limit_r  <= pwdata;
        REG_USER_MASK:  user_mask_r  <= pwdata;
        REG_GUARD_MASK: guard_mask_r <= pwdata;
        REG_SPACE_RDY:  space_rdy_r  <= pwdata[0];
        REG_PROC_OWN:   proc_own_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign base_cur  = addr_r & PAGE_MASK;
  assign flags_new = (req_r | user_mask_r) & ~guard_mask_r;
  assign last      = (idx_r == SLOT_LAST);

  // operand select for the one adder
  always_comb begin
    add_a   = addr_r;
    add_b   = len_r;
    add_cin = 1'b0;
    unique case (state_r)
      S_ROUND: begin
        add_a = acc_r;
        add_b = PAGE_ADD;
      end
      S_CHECK: begin
        add_a   = acc_r;
        add_b   = ~base_cur;
        add_cin = 1'b1;
      end
      S_LOOK: begin
        add_a = slot_base_r[idx_r];
        add_b = slot_size_r[idx_r];
      end
      default: ;
    endcase
  end

  assign sum = add_a + add_b + 64'(add_cin);

  assign good = space_rdy_r & proc_own_r & (len_r != 64'd0) & (acc_r > base_cur) &
                (base_cur >= win_base_r) & (acc_r <= win_limit_r);
  assign hit  = used_r[idx_r] & (addr_r >= slot_base_r[idx_r]) & (addr_r < sum);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    used_nxt   = used_r;
    total_nxt  = total_r;
    acc_nxt    = acc_r;
    size_nxt   = size_r;
    wr_en      = 1'b0;
    emit       = 1'b0;
    emit_ok    = 1'b0;
    emit_base  = '0;
    emit_bytes = '0;
    emit_flags = '0;
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (start) begin
          state_nxt = in_kind ? S_LOOK : S_ADD;
        end
      end
      S_ADD: begin
        acc_nxt   = sum;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        acc_nxt   = sum & PAGE_MASK;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        size_nxt = sum;
        if (good) begin
          state_nxt = S_FIND;
        end else begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FIND: begin
        if (!used_r[idx_r]) begin
          state_nxt = S_WRITE;
        end else if (last) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_WRITE: begin
        wr_en           = 1'b1;
        used_nxt[idx_r] = 1'b1;
        total_nxt       = total_r + 5'd1;
        emit            = 1'b1;
        emit_ok         = 1'b1;
        emit_base       = base_cur;
        emit_bytes      = size_r;
        emit_flags      = flags_new;
        state_nxt       = S_IDLE;
      end
      S_LOOK: begin
        if (hit) begin
          emit       = 1'b1;
          emit_ok    = 1'b1;
          emit_base  = slot_base_r[idx_r];
          emit_bytes = slot_size_r[idx_r];
          emit_flags = slot_flags_r[idx_r];
          state_nxt  = S_IDLE;
        end else if (last) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      used_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      addr_r <= in_address;
      len_r  <= in_length;
      req_r  <= in_request_flags;
    end
    acc_r  <= acc_nxt;
    size_r <= size_nxt;
    if (wr_en) begin
      slot_base_r[idx_r]  <= base_cur;
      slot_size_r[idx_r]  <= size_r;
      slot_flags_r[idx_r] <= flags_new;
    end
    if (emit) begin
      out_ok_r    <= emit_ok;
      out_slot_r  <= emit_ok ? slot_out(idx_r) : 4'd0;
      out_base_r  <= emit_base;
      out_bytes_r <= emit_bytes;
      out_flags_r <= emit_flags;
      out_total_r <= total_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_slot         = out_slot_r;
  assign out_region_base  = out_base_r;
  assign out_region_bytes = out_bytes_r;
  assign out_region_flags = out_flags_r;
  assign out_region_total = out_total_r;

  `URRT_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r)
  `URRT_ASSERT_NOW(a_strobe_after_work, out_valid_r, $past(busy))
  `URRT_ASSERT_NOW(a_count_on_reserve, total_r != $past(total_r), out_valid_r && out_ok_r)
  `URRT_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy)

endmodule

@@ sim/tb_user_region_reserve_table_core.sv @@
`timescale 1ns / 1ps

module tb_user_region_reserve_table_core;
  import urrt_pkg::*;

  localparam logic KIND_RESERVE = 1'b0;
  localparam logic KIND_LOOKUP  = 1'b1;
  localparam int unsigned TABLE_DEPTH = REGION_SLOTS;
  localparam logic [63:0] PAGE_SIZE = PAGE_BYTES;
  localparam logic [63:0] PAGE_KEEP = ~(PAGE_SIZE - 64'd1);
  localparam logic [63:0] ALL_ONES = '1;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot;
    logic [63:0] base;
    logic [63:0] bytes;
    logic [63:0] flags;
    logic [4:0]  total;
  } region_reply_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_kind;
  logic [63:0] in_address;
  logic [63:0] in_length;
  logic [63:0] in_request_flags;
  logic out_valid;
  logic out_ok;
  logic [3:0] out_slot;
  logic [63:0] out_region_base;
  logic [63:0] out_region_bytes;
  logic [63:0] out_region_flags;
  logic [4:0] out_region_total;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  // predictor copy of configuration and table
  logic [63:0] win_base;
  logic [63:0] win_limit;
  logic [63:0] force_on;
  logic [63:0] force_off;
  logic        space_rdy;
  logic        owned;
  logic        tbl_used [TABLE_DEPTH];
  logic [63:0] tbl_base [TABLE_DEPTH];
  logic [63:0] tbl_size [TABLE_DEPTH];
  logic [63:0] tbl_flags [TABLE_DEPTH];
  logic [4:0]  region_count;

  region_reply_t pending_replies[$];
  int errors;
  int stall_cycles;
  bit no_idle;

  user_region_reserve_table_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_address       (in_address),
    .in_length        (in_length),
    .in_request_flags (in_request_flags),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_slot         (out_slot),
    .out_region_base  (out_region_base),
    .out_region_bytes (out_region_bytes),
    .out_region_flags (out_region_flags),
    .out_region_total (out_region_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // reserve or look up in the predictor table; returns the reply it expects
  function automatic region_reply_t apply_request(input logic k, input logic [63:0] addr,
                                                  input logic [63:0] len,
                                                  input logic [63:0] req);
    region_reply_t r;
    logic [63:0] lo;
    logic [63:0] hi;
    bit good;
    int hit;
    r = '0;
    hit = -1;
    if (k == KIND_RESERVE) begin
      lo = addr & PAGE_KEEP;
      hi = (addr + len + PAGE_SIZE - 64'd1) & PAGE_KEEP;
      good = space_rdy && owned && (len != 64'd0) && (hi > lo) &&
             (lo >= win_base) && (hi <= win_limit);
      if (good) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (hit < 0 && !tbl_used[i]) hit = i;
        end
      end
      if (hit >= 0) begin
        tbl_used[hit] = 1'b1;
        tbl_base[hit] = lo;
        tbl_size[hit] = hi - lo;
        tbl_flags[hit] = (req | force_on) & ~force_off;
        region_count = region_count + 5'd1;
      end
    end else begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (hit < 0 && tbl_used[i] && addr >= tbl_base[i] &&
            addr < tbl_base[i] + tbl_size[i]) hit = i;
      end
    end
    if (hit >= 0) begin
      r.ok = 1'b1;
      r.slot = hit[3:0];
      r.base = tbl_base[hit];
      r.bytes = tbl_size[hit];
      r.flags = tbl_flags[hit];
    end
    r.total = region_count;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    region_reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: ok %b slot %0d", $time, out_ok, out_slot);
      end else begin
        want = pending_replies.pop_front();
        check_field("ok", 64'(want.ok), 64'(out_ok));
        check_field("slot", 64'(want.slot), 64'(out_slot));
        check_field("region_base", want.base, out_region_base);
        check_field("region_bytes", want.bytes, out_region_bytes);
        check_field("region_flags", want.flags, out_region_flags);
        check_field("region_total", 64'(want.total), 64'(out_region_total));
      end
    end
  end

  // counts cycles without any beat on any port
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pwrite)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(input logic k, input logic [63:0] addr,
                              input logic [63:0] len, input logic [63:0] req);
    if (!no_idle && $urandom_range(99) < 34) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= k;
    in_address <= addr;
    in_length <= len;
    in_request_flags <= req;
    do @(posedge clk); while (busy);
    pending_replies.push_back(apply_request(k, addr, len, req));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0 || busy) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [63:0] v);
    logic [63:0] readback;
    readback = (r == REG_SPACE_RDY || r == REG_PROC_OWN) ? {63'd0, v[0]} : v;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'({r, 3'b000});
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    // address still held, so the register reads back here
    check_field("prdata", readback, prdata);
    case (r)
      REG_WIN_BASE:   win_base = v;
      REG_WIN_LIMIT:  win_limit = v;
      REG_USER_MASK:  force_on = v;
      REG_GUARD_MASK: force_off = v;
      REG_SPACE_RDY:  space_rdy = v[0];
      REG_PROC_OWN:   owned = v[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [63:0] base, input logic [63:0] limit,
                            input logic [63:0] on_mask, input logic [63:0] off_mask,
                            input logic [63:0] rdy_word, input logic [63:0] own_word);
    wait_idle();
    write_reg(REG_WIN_BASE, base);
    write_reg(REG_WIN_LIMIT, limit);
    write_reg(REG_USER_MASK, on_mask);
    write_reg(REG_GUARD_MASK, off_mask);
    write_reg(REG_SPACE_RDY, rdy_word);
    write_reg(REG_PROC_OWN, own_word);
  endtask

  // everything zero after reset: reserves refused, table empty
  task automatic test_closed_space();
    send_request(KIND_RESERVE, 64'h1000, 64'h1000, ALL_ONES);
    send_request(KIND_LOOKUP, 64'h0, 64'h0, 64'h0);
    send_request(KIND_LOOKUP, ALL_ONES, ALL_ONES, ALL_ONES);
  endtask

  task automatic test_reserve_checks();
    set_config(64'h1_0000, 64'h1_0000_0000, 64'h8000_0000_0000_0005,
               64'h3000_0000_0000_00f0, 64'h1, 64'h1);
    send_request(KIND_RESERVE, 64'h2_0000, 64'h0, 64'h0);
    send_request(KIND_RESERVE, 64'hf000, 64'h10, 64'h0);
    send_request(KIND_RESERVE, 64'hffff_f000, 64'h1001, 64'h0);
    // end lands exactly on the limit
    send_request(KIND_RESERVE, 64'hffff_f123, 64'hedd, 64'h0123_4567_89ab_cdef);
    // unaligned start and length spill onto a second page
    send_request(KIND_RESERVE, 64'h2_0fff, 64'h2, ALL_ONES);
    send_request(KIND_RESERVE, 64'h3_0000, 64'h1000, 64'h0);
    send_request(KIND_LOOKUP, 64'h2_0000, 64'h0, 64'h0);
    send_request(KIND_LOOKUP, 64'h2_1fff, ALL_ONES, ALL_ONES);
    send_request(KIND_LOOKUP, 64'h2_2000, 64'h0, 64'h0);
    send_request(KIND_LOOKUP, 64'hffff_ffff, 64'h0, 64'h0);
  endtask

  // ready and ownership bits each block a reserve; only bit 0 counts
  task automatic test_gate_bits();
    set_config(64'h1_0000, 64'h1_0000_0000, 64'h0, 64'h0, ~64'h1, 64'h1);
    send_request(KIND_RESERVE, 64'h5_0000, 64'h100, 64'h0);
    set_config(64'h1_0000, 64'h1_0000_0000, 64'h0, 64'h0, ALL_ONES, ~64'h1);
    send_request(KIND_RESERVE, 64'h5_0000, 64'h100, 64'h0);
  endtask

  task automatic test_window_extremes();
    set_config(64'h0, ALL_ONES, ALL_ONES, 64'h0, 64'h1, 64'h1);
    send_request(KIND_RESERVE, 64'h0, 64'h1, 64'h0);
    send_request(KIND_RESERVE, 64'hffff_ffff_ffff_e000, 64'h1000, 64'h0);
    // end wraps to zero
    send_request(KIND_RESERVE, 64'hffff_ffff_ffff_f000, 64'h1, 64'h0);
    // sum wraps below the base
    send_request(KIND_RESERVE, 64'h5000, ALL_ONES, 64'h0);
    send_request(KIND_LOOKUP, 64'hffff_ffff_ffff_efff, 64'h0, 64'h0);
    send_request(KIND_LOOKUP, ALL_ONES, 64'h0, 64'h0);
    set_config(ALL_ONES, ALL_ONES, 64'h0, ALL_ONES, ALL_ONES, ALL_ONES);
    send_request(KIND_RESERVE, ALL_ONES, 64'h1, ALL_ONES);
  endtask

  task automatic test_random_traffic();
    logic [63:0] wb;
    logic [63:0] span;
    logic [63:0] addr;
    logic [63:0] len;
    int used;
    int j;
    for (int p = 0; p < 4; p++) begin
      if (p == 3) begin
        wb = 64'h0;
        span = ALL_ONES;
      end else begin
        wb = rand64() >> $urandom_range(8, 63);
        span = (rand64() >> $urandom_range(16, 40)) + 64'h10_0000;
      end
      set_config(wb, (wb + span < wb) ? ALL_ONES : wb + span, rand64(), rand64() >> 8,
                 rand64() | 64'h1, rand64() | 64'h1);
      no_idle = (p == 1);
      for (int n = 0; n < 100; n++) begin
        if (n == 50) wait_idle();
        used = (region_count > TABLE_DEPTH) ? TABLE_DEPTH : region_count;
        if ($urandom_range(99) < 35) begin
          if (used < 4 * (p + 2) && $urandom_range(3) != 0) begin
            addr = win_base + rand64() % (win_limit - win_base);
            len = 64'($urandom_range(1, 'h9000));
          end else begin
            addr = rand64();
            len = ($urandom_range(3) == 0) ? 64'h0 : rand64() >> $urandom_range(0, 63);
          end
          send_request(KIND_RESERVE, addr, len, rand64());
        end else begin
          if (used > 0 && $urandom_range(3) != 0) begin
            j = $urandom_range(used - 1);
            addr = tbl_base[j] + rand64() % (tbl_size[j] + 64'd2) - 64'd1;
          end else begin
            addr = rand64();
          end
          send_request(KIND_LOOKUP, addr, rand64(), rand64());
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    errors = 0;
    no_idle = 1'b0;
    win_base = '0;
    win_limit = '0;
    force_on = '0;
    force_off = '0;
    space_rdy = 1'b0;
    owned = 1'b0;
    region_count = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_used[i] = 1'b0;
      tbl_base[i] = '0;
      tbl_size[i] = '0;
      tbl_flags[i] = '0;
    end
    stall_cycles <= 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_kind <= KIND_RESERVE;
    in_address <= '0;
    in_length <= '0;
    in_request_flags <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_closed_space();
    test_reserve_checks();
    test_gate_bits();
    test_window_extremes();
    test_random_traffic();

    wait_idle();
    repeat (30) @(posedge clk);
    if (pending_replies.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_replies.size());
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/urrt_pkg.sv
rtl/user_region_reserve_table_core.sv
sim/tb_user_region_reserve_table_core.sv
